// ----- rtl/usbep0_pkg.sv -----
// usbep0_pkg: shared types, codes and constant helpers for the EP0 stage sequencer.
// No dependencies; every other file imports this package.
package usbep0_pkg;

  localparam int OP_W   = 3;
  localparam int LEN_W  = 7;
  localparam int DATA_W = 16;
  localparam int ADDR_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_START_IN   = 3'd0,
    OP_START_OUT  = 3'd1,
    OP_ACK_NODATA = 3'd2,
    OP_SET_ADDR   = 3'd3,
    OP_IN_DONE    = 3'd4,
    OP_OUT_DONE   = 3'd5,
    OP_REJECT     = 3'd6,
    OP_STATUS_OUT = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    ACT_SEND_IN      = 4'd0,
    ACT_SEND_ZLP     = 4'd1,
    ACT_ARM_OUT      = 4'd2,
    ACT_ARM_STATUS   = 4'd3,
    ACT_STALL        = 4'd4,
    ACT_SET_ADDR     = 4'd5,
    ACT_REOPEN_IN    = 4'd6,
    ACT_CLASS_DATA   = 4'd7,
    ACT_CLASS_STATUS = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    IN_UNK    = 2'd0,
    IN_ZLP    = 2'd1,
    IN_DATA   = 2'd2,
    IN_STATUS = 2'd3
  } in_stage_t;

  typedef enum logic [1:0] {
    OUT_UNK  = 2'd0,
    OUT_ZLP  = 2'd1,
    OUT_DATA = 2'd2
  } out_stage_t;

  typedef struct packed {
    logic cpend;
    logic cwrite;
    logic cread;
    logic armed;
    logic zlp;
  } flags_t;

  // Registered event plus the fields derived from it on entry.
  typedef struct packed {
    opcode_t             op;
    logic [DATA_W-1:0]   dlen;
    logic                rlen_nz;
    logic                early;
    logic                cls;
    logic [ADDR_W-1:0]   addr;
    logic                busy;
    logic [DATA_W-1:0]   size;
    logic                zlp_need;
    logic                dlen_lt_rlen;
  } item_t;

  typedef struct packed {
    action_t             action;
    logic [LEN_W-1:0]    len;
    logic [DATA_W-1:0]   off;
    logic [ADDR_W-1:0]   addr;
    logic                last;
  } result_t;

  // Up to two results produced by one event.
  typedef struct packed {
    logic [1:0]          count;
    result_t [1:0]       res;
  } batch_t;

  function automatic int tz_of(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    for (int i = 0; i < 7; i++) begin
      if ((x & 1) == 0 && x != 0) begin
        n = n + 1;
        x = x >> 1;
      end
    end
    return n;
  endfunction

  // Multiplicative inverse of an odd value modulo 2^16 (Newton iteration).
  function automatic logic [15:0] odd_inv16(input logic [15:0] m);
    logic [31:0] x;
    logic [31:0] t;
    x = {16'd0, m};
    for (int i = 0; i < 5; i++) begin
      t = 32'd2 - ((32'(m) * x) & 32'h0000_FFFF);
      x = (x * t) & 32'h0000_FFFF;
    end
    return x[15:0];
  endfunction

endpackage

// ----- rtl/usbep0_in_if.sv -----
// usbep0_in_if: valid/ready channel carrying one EP0 event beat.
// Depends on usbep0_pkg for field widths.
interface usbep0_in_if;
  import usbep0_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [DATA_W-1:0]   data_length;
  logic [DATA_W-1:0]   request_length;
  logic                early_status;
  logic                class_request;
  logic [ADDR_W-1:0]   device_address;
  logic [LEN_W-1:0]    actual_length;
  logic                in_busy;

  modport source (
    output valid, opcode, data_length, request_length, early_status, class_request,
           device_address, actual_length, in_busy,
    input  ready
  );
  modport sink (
    input  valid, opcode, data_length, request_length, early_status, class_request,
           device_address, actual_length, in_busy,
    output ready
  );
endinterface

// ----- rtl/usbep0_out_if.sv -----
// usbep0_out_if: valid/ready channel carrying one result beat.
// Depends on usbep0_pkg for field widths.
interface usbep0_out_if;
  import usbep0_pkg::*;
  logic                valid;
  logic                ready;
  logic [3:0]          action;
  logic [LEN_W-1:0]    packet_length;
  logic [DATA_W-1:0]   buffer_offset;
  logic [ADDR_W-1:0]   address_out;
  logic                last;

  modport source (
    output valid, action, packet_length, buffer_offset, address_out, last,
    input  ready
  );
  modport sink (
    input  valid, action, packet_length, buffer_offset, address_out, last,
    output ready
  );
endinterface

// ----- rtl/usbep0_front.sv -----
// usbep0_front: input register; clips the IN length and flags an exact-multiple answer.
// Depends on usbep0_pkg and usbep0_in_if.
module usbep0_front #(
  parameter int MAX_PACKET = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  usbep0_in_if.sink            in_chan,
  input  logic                 take,
  output logic                 item_v,
  output usbep0_pkg::item_t    item
);
  import usbep0_pkg::*;

  localparam int          TZ      = tz_of(MAX_PACKET);
  localparam int          ODD     = MAX_PACKET >> TZ;
  localparam logic [15:0] INV     = odd_inv16(16'(ODD));
  localparam logic [15:0] LIM     = 16'(65535 / ODD);
  localparam logic [15:0] LOWMASK = 16'((1 << TZ) - 1);

  logic              v_r;
  item_t             item_r;
  item_t             item_nxt;
  logic              accept;
  logic [15:0]       dlen;
  logic [15:0]       rlen;
  logic [15:0]       size;
  logic [15:0]       host;
  logic [15:0]       shifted;
  logic [31:0]       prod;
  logic              multiple;

  assign in_chan.ready = !v_r || take;
  assign accept        = in_chan.valid && in_chan.ready;
  assign dlen          = in_chan.data_length;
  assign rlen          = in_chan.request_length;

  always_comb begin
    size     = (rlen != '0 && rlen < dlen) ? rlen : dlen;
    host     = (rlen != '0) ? rlen : dlen;
    shifted  = size >> TZ;
    // divisibility by the odd part: x*inv mod 2^16 stays at or below the limit
    prod     = 32'(shifted) * 32'(INV);
    multiple = ((size & LOWMASK) == '0) && (prod[15:0] <= LIM);

    item_nxt.op           = opcode_t'(in_chan.opcode);
    item_nxt.dlen         = dlen;
    item_nxt.rlen_nz      = (rlen != '0);
    item_nxt.early        = in_chan.early_status;
    item_nxt.cls          = in_chan.class_request;
    item_nxt.addr         = in_chan.device_address;
    item_nxt.busy         = in_chan.in_busy;
    item_nxt.size         = size;
    item_nxt.zlp_need     = (host > size) && multiple;
    item_nxt.dlen_lt_rlen = (dlen < rlen);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (take) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_v = v_r;
  assign item   = item_r;

endmodule

// ----- rtl/usbep0_core.sv -----
// usbep0_core: control-transfer stage state and per-event result generation.
// Depends on usbep0_pkg.
module usbep0_core #(
  parameter int MAX_PACKET = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_v,
  input  usbep0_pkg::item_t    item,
  input  logic                 free,
  output logic                 fire,
  output usbep0_pkg::batch_t   batch
);
  import usbep0_pkg::*;

  localparam logic [DATA_W-1:0] MP16 = DATA_W'(MAX_PACKET);
  localparam logic [LEN_W-1:0]  MP7  = LEN_W'(MAX_PACKET);

  in_stage_t          in_stage_r,  in_stage_nxt;
  out_stage_t         out_stage_r, out_stage_nxt;
  logic [DATA_W-1:0]  in_rem_r,    in_rem_nxt;
  logic [DATA_W-1:0]  in_off_r,    in_off_nxt;
  logic [DATA_W-1:0]  out_rem_r,   out_rem_nxt;
  logic [DATA_W-1:0]  out_off_r,   out_off_nxt;
  flags_t             flags_r,     flags_nxt;

  logic [DATA_W-1:0]  ic_src, ic_off, ic_rem;
  logic               ic_gt;
  logic [LEN_W-1:0]   ic_len;
  logic [DATA_W-1:0]  oc_src, oc_off, oc_rem;
  logic               oc_gt;
  logic [LEN_W-1:0]   oc_len;
  logic               stall;
  batch_t             b;

  function automatic result_t mk_res(input action_t a, input logic [LEN_W-1:0] l,
                                     input logic [DATA_W-1:0] o,
                                     input logic [ADDR_W-1:0] ad);
    result_t r;
    r.action = a;
    r.len    = l;
    r.off    = o;
    r.addr   = ad;
    r.last   = 1'b0;
    return r;
  endfunction

  assign fire = item_v && free;

  // chunk splitting for the IN and OUT data stages
  always_comb begin
    ic_src = (item.op == OP_START_IN) ? item.size : in_rem_r;
    ic_off = (item.op == OP_START_IN) ? '0 : in_off_r;
    ic_gt  = ic_src > MP16;
    ic_rem = ic_src - MP16;
    ic_len = ic_gt ? MP7 : ic_src[LEN_W-1:0];
    oc_src = (item.op == OP_START_OUT) ? item.dlen : out_rem_r;
    oc_off = (item.op == OP_START_OUT) ? '0 : out_off_r + MP16;
    oc_gt  = oc_src > MP16;
    oc_rem = oc_src - MP16;
    oc_len = oc_gt ? MP7 : oc_src[LEN_W-1:0];
  end

  always_comb begin
    in_stage_nxt  = in_stage_r;
    out_stage_nxt = out_stage_r;
    in_rem_nxt    = in_rem_r;
    in_off_nxt    = in_off_r;
    out_rem_nxt   = out_rem_r;
    out_off_nxt   = out_off_r;
    flags_nxt     = flags_r;
    stall         = 1'b0;
    b             = '0;

    if (fire) begin
      if (item.op != OP_IN_DONE && item.op != OP_OUT_DONE) begin
        flags_nxt.cread  = 1'b0;
        flags_nxt.cwrite = 1'b0;
        flags_nxt.cpend  = 1'b0;
      end

      case (item.op)
        OP_START_IN: begin
          if (item.cls && !item.rlen_nz) begin
            stall = 1'b1;
          end else begin
            if (item.cls) begin
              flags_nxt.cwrite = 1'b1;
              flags_nxt.cpend  = 1'b1;
            end
            in_stage_nxt    = IN_DATA;
            in_off_nxt      = '0;
            in_rem_nxt      = '0;
            flags_nxt.armed = 1'b0;
            flags_nxt.zlp   = item.zlp_need;
            if (item.size == '0) begin
              stall = 1'b1;
            end else begin
              if (ic_gt) begin
                in_rem_nxt = ic_rem;
                in_off_nxt = ic_off + MP16;
              end else if (!flags_nxt.zlp) begin
                out_stage_nxt   = OUT_ZLP;
                flags_nxt.armed = 1'b1;
                b.res[b.count[0]] = mk_res(ACT_ARM_STATUS, '0, '0, '0);
                b.count = b.count + 2'd1;
              end
              if (item.early && !flags_nxt.armed) begin
                out_stage_nxt   = OUT_ZLP;
                flags_nxt.armed = 1'b1;
                b.res[b.count[0]] = mk_res(ACT_ARM_STATUS, '0, '0, '0);
                b.count = b.count + 2'd1;
              end
              b.res[b.count[0]] = mk_res(ACT_SEND_IN, ic_len, ic_off, '0);
              b.count = b.count + 2'd1;
            end
          end
        end

        OP_START_OUT: begin
          if (item.cls && (!item.rlen_nz || item.dlen_lt_rlen)) begin
            stall = 1'b1;
          end else begin
            if (item.cls) begin
              flags_nxt.cread = 1'b1;
            end
            out_off_nxt   = '0;
            out_rem_nxt   = '0;
            out_stage_nxt = OUT_DATA;
            if (item.dlen == '0) begin
              stall = 1'b1;
            end else begin
              out_rem_nxt = oc_gt ? oc_rem : '0;
              b.res[b.count[0]] = mk_res(ACT_ARM_OUT, oc_len, oc_off, '0);
              b.count = b.count + 2'd1;
            end
          end
        end

        OP_ACK_NODATA: begin
          in_stage_nxt = IN_ZLP;
          b.res[b.count[0]] = mk_res(ACT_SEND_ZLP, '0, '0, '0);
          b.count = b.count + 2'd1;
        end

        OP_SET_ADDR: begin
          in_stage_nxt = IN_STATUS;
          b.res[0] = mk_res(ACT_SEND_ZLP, '0, '0, '0);
          b.res[1] = mk_res(ACT_SET_ADDR, '0, '0, item.addr);
          b.count  = 2'd2;
        end

        OP_IN_DONE: begin
          in_stage_nxt = IN_UNK;
          case (in_stage_r)
            IN_ZLP, IN_STATUS: begin
            end
            IN_DATA: begin
              if (in_rem_r != '0) begin
                in_stage_nxt = IN_DATA;
                if (ic_gt) begin
                  in_rem_nxt = ic_rem;
                  in_off_nxt = ic_off + MP16;
                end else begin
                  in_rem_nxt = '0;
                  if (!flags_r.zlp && !flags_r.armed) begin
                    out_stage_nxt   = OUT_ZLP;
                    flags_nxt.armed = 1'b1;
                    b.res[b.count[0]] = mk_res(ACT_ARM_STATUS, '0, '0, '0);
                    b.count = b.count + 2'd1;
                  end
                end
                b.res[b.count[0]] = mk_res(ACT_SEND_IN, ic_len, ic_off, '0);
                b.count = b.count + 2'd1;
              end else if (flags_r.zlp) begin
                flags_nxt.zlp = 1'b0;
                if (!flags_r.armed) begin
                  out_stage_nxt   = OUT_ZLP;
                  flags_nxt.armed = 1'b1;
                  b.res[b.count[0]] = mk_res(ACT_ARM_STATUS, '0, '0, '0);
                  b.count = b.count + 2'd1;
                end
                in_stage_nxt = IN_ZLP;
                b.res[b.count[0]] = mk_res(ACT_SEND_ZLP, '0, '0, '0);
                b.count = b.count + 2'd1;
              end else if (flags_r.cwrite) begin
                flags_nxt.cwrite = 1'b0;
                if (!flags_r.cpend) begin
                  flags_nxt.cread = 1'b0;
                end
                b.res[b.count[0]] = mk_res(ACT_CLASS_DATA, '0, '0, '0);
                b.count = b.count + 2'd1;
              end
            end
            default: begin
              stall = 1'b1;
            end
          endcase
        end

        OP_OUT_DONE: begin
          out_stage_nxt = OUT_UNK;
          case (out_stage_r)
            OUT_ZLP: begin
              flags_nxt.armed = 1'b0;
              if (item.busy) begin
                in_stage_nxt = IN_ZLP;
                in_rem_nxt   = '0;
                b.res[b.count[0]] = mk_res(ACT_REOPEN_IN, '0, '0, '0);
                b.count = b.count + 2'd1;
              end else if (flags_r.armed && flags_r.cpend) begin
                flags_nxt.cread  = 1'b0;
                flags_nxt.cwrite = 1'b0;
                flags_nxt.cpend  = 1'b0;
                b.res[b.count[0]] = mk_res(ACT_CLASS_STATUS, '0, '0, '0);
                b.count = b.count + 2'd1;
              end
            end
            OUT_DATA: begin
              if (out_rem_r != '0) begin
                out_off_nxt   = oc_off;
                out_stage_nxt = OUT_DATA;
                out_rem_nxt   = oc_gt ? oc_rem : '0;
                b.res[b.count[0]] = mk_res(ACT_ARM_OUT, oc_len, oc_off, '0);
                b.count = b.count + 2'd1;
              end else begin
                if (flags_r.cread) begin
                  flags_nxt.cread  = 1'b0;
                  flags_nxt.cwrite = 1'b0;
                  flags_nxt.cpend  = 1'b0;
                  b.res[b.count[0]] = mk_res(ACT_CLASS_DATA, '0, '0, '0);
                  b.count = b.count + 2'd1;
                end
                in_stage_nxt = IN_ZLP;
                b.res[b.count[0]] = mk_res(ACT_SEND_ZLP, '0, '0, '0);
                b.count = b.count + 2'd1;
              end
            end
            default: begin
              stall = 1'b1;
            end
          endcase
        end

        OP_REJECT: begin
          stall = 1'b1;
        end

        default: begin
          out_stage_nxt = OUT_ZLP;
          b.res[b.count[0]] = mk_res(ACT_ARM_STATUS, '0, '0, '0);
          b.count = b.count + 2'd1;
        end
      endcase

      // a stall is always the only result of its event
      if (stall) begin
        b.res[0] = mk_res(ACT_STALL, '0, '0, '0);
        b.count  = 2'd1;
      end
      if (b.count == 2'd1) begin
        b.res[0].last = 1'b1;
      end else if (b.count == 2'd2) begin
        b.res[1].last = 1'b1;
      end
    end
  end

  assign batch = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_stage_r  <= IN_UNK;
      out_stage_r <= OUT_UNK;
      in_rem_r    <= '0;
      in_off_r    <= '0;
      out_rem_r   <= '0;
      out_off_r   <= '0;
      flags_r     <= '0;
    end else begin
      in_stage_r  <= in_stage_nxt;
      out_stage_r <= out_stage_nxt;
      in_rem_r    <= in_rem_nxt;
      in_off_r    <= in_off_nxt;
      out_rem_r   <= out_rem_nxt;
      out_off_r   <= out_off_nxt;
      flags_r     <= flags_nxt;
    end
  end

endmodule

// ----- rtl/usbep0_emit.sv -----
// usbep0_emit: two-entry result queue, drained one beat per cycle on ready.
// Depends on usbep0_pkg and usbep0_out_if.
module usbep0_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  usbep0_pkg::batch_t   batch,
  output logic                 free,
  output logic [1:0]           count,
  usbep0_out_if.source         out_chan
);
  import usbep0_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic       pop;

  assign pop  = (cnt_r != 2'd0) && out_chan.ready;
  assign free = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_chan.ready);

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      slot0_nxt = batch.res[0];
      slot1_nxt = batch.res[1];
      cnt_nxt   = batch.count;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign count                  = cnt_r;
  assign out_chan.valid         = (cnt_r != 2'd0);
  assign out_chan.action        = slot0_r.action;
  assign out_chan.packet_length = slot0_r.len;
  assign out_chan.buffer_offset = slot0_r.off;
  assign out_chan.address_out   = slot0_r.addr;
  assign out_chan.last          = slot0_r.last;

endmodule

// ----- rtl/usb_ep0_control_stage_sequencer_unit.sv -----
// usb_ep0_control_stage_sequencer_unit: top level of the EP0 control stage sequencer.
// Depends on usbep0_pkg, usbep0_in_if, usbep0_out_if, usbep0_front, usbep0_core,
// usbep0_emit.
//
// Usage: each beat on in_chan is one endpoint-zero event (setup decode result or
// packet completion). The block answers on out_chan with zero, one or two action
// beats; the final beat of an event carries last. Events without an action give
// no beat at all.
// Path: an accepted event is held in the input register, its results are computed
// combinationally and loaded into the result queue, whose head drives out_chan.
// Throughput: one event per cycle while each event yields at most one result and
// out_chan.ready is high; an event with two results holds the sequencer until the
// queue is down to one entry, since the result queue drains one beat per cycle.
// Stalls: when out_chan.ready is low, results wait in the two-entry queue, the
// input register holds one more event, and in_chan.ready drops after that.
// Reset (rst_n low, synchronous): stages go to unknown, counters and flags
// clear, both channels are empty.
module usb_ep0_control_stage_sequencer_unit #(
  parameter int MAX_PACKET = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  usbep0_in_if.sink     in_chan,
  usbep0_out_if.source  out_chan
);
  import usbep0_pkg::*;

  logic       item_v;
  item_t      item;
  logic       fire;
  logic       free;
  batch_t     batch;
  logic [1:0] q_count;

  usbep0_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (fire),
    .item_v  (item_v),
    .item    (item)
  );

  usbep0_core #(.MAX_PACKET(MAX_PACKET)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_v (item_v),
    .item   (item),
    .free   (free),
    .fire   (fire),
    .batch  (batch)
  );

  usbep0_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .batch    (batch),
    .free     (free),
    .count    (q_count),
    .out_chan (out_chan)
  );

  a_batch_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (batch.count != 2'd3))
    else $error("event produced more than two results");

  a_batch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && batch.count == 2'd2) |-> (!batch.res[0].last && batch.res[1].last))
    else $error("last flag misplaced in two-result event");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (q_count == 2'd0 || (q_count == 2'd1 && out_chan.ready)))
    else $error("result queue overrun");

  a_event_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last) |=> out_chan.valid)
    else $error("event results split by a gap");

endmodule
